### hw/rtl/idba_pkg.sv
// Shared types, constants and bit search functions for the id bitmap allocator.
package idba_pkg;

    localparam int MAP_WORDS = 64;
    localparam int WORD_BITS = 64;
    localparam int WORD_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CMD_W     = 2;
    localparam int ID_W      = 12;
    localparam int STATUS_W  = 2;

    localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MARK  = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_IN_USE      = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_MOD  = 1'b1
    } t_state;

    typedef struct packed {
        logic                 en;
        logic [WORD_W-1:0]    addr;
        logic [WORD_BITS-1:0] data;
    } t_map_wr;

    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] addr;
        logic              nonzero;
    } t_sum_upd;

    function automatic logic [BIT_W-1:0] ffs_word(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [WORD_W-1:0] ffs_map(input logic [MAP_WORDS-1:0] v);
        logic [WORD_W-1:0] idx;
        idx = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = WORD_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### hw/rtl/idba_map_ram.sv
// Bitmap word memory with per-word valid bits so unwritten words read as all free.
module idba_map_ram (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [idba_pkg::WORD_W-1:0]          i_rd_addr,
    input  idba_pkg::t_map_wr                    i_wr,
    output logic [idba_pkg::WORD_BITS-1:0]       o_rd_data
);

    logic [idba_pkg::WORD_BITS-1:0] r_mem [idba_pkg::MAP_WORDS];
    logic [idba_pkg::MAP_WORDS-1:0] r_valid;
    logic [idba_pkg::WORD_BITS-1:0] r_rd_data;
    logic                           r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : idba_pkg::WORD_ONES;

endmodule

### hw/rtl/idba_summary.sv
// Summary vector of nonzero bitmap words and search for the first one.
module idba_summary (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  idba_pkg::t_sum_upd          i_upd,
    output logic                        o_any,
    output logic [idba_pkg::WORD_W-1:0] o_first
);

    logic [idba_pkg::MAP_WORDS-1:0] r_nonzero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonzero <= '1;
        end else if (i_upd.en) begin
            r_nonzero[i_upd.addr] <= i_upd.nonzero;
        end
    end

    assign o_any   = |r_nonzero;
    assign o_first = idba_pkg::ffs_map(r_nonzero);

endmodule

### hw/rtl/id_bitmap_allocator.sv
// Top level of the id bitmap allocator: request sequencer and result register.
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_stall   i_cmd, i_id_number
//   result    out        o_out_valid / i_out_stall o_status, o_granted_id
//
// Each request passes through S_IDLE, which reads the bitmap word, and S_MOD, which
// modifies it, writes it back and loads the result register; the registered memory
// read and the write back that must land before the next read set this.
// A request may be taken while the previous result still waits in its register.
// Reset is synchronous, active low; the bitmap reads as all free right after it.
// A held result stalls the S_MOD step of the next request until it is taken.
module id_bitmap_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [idba_pkg::CMD_W-1:0]    i_cmd,
    input  logic [idba_pkg::ID_W-1:0]     i_id_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [idba_pkg::STATUS_W-1:0] o_status,
    output logic [idba_pkg::ID_W-1:0]     o_granted_id
);

    idba_pkg::t_state                r_state, n_state;
    logic [idba_pkg::CMD_W-1:0]      r_cmd;
    logic [idba_pkg::WORD_W-1:0]     r_addr;
    logic [idba_pkg::BIT_W-1:0]      r_bit;
    logic                            r_found;
    logic                            r_in_range;
    logic                            r_out_valid;
    logic [idba_pkg::STATUS_W-1:0]   r_status;
    logic [idba_pkg::ID_W-1:0]       r_granted;

    logic                            accept;
    logic                            out_free;
    logic                            done;
    logic                            rd_en;
    logic [idba_pkg::WORD_W-1:0]     rd_addr;
    logic [idba_pkg::WORD_BITS-1:0]  rd_word;
    logic [idba_pkg::ID_W-1:0]       id_word;
    logic                            id_in_range;
    logic                            sum_any;
    logic [idba_pkg::WORD_W-1:0]     sum_first;
    logic [idba_pkg::BIT_W-1:0]      alloc_bit;
    logic [idba_pkg::WORD_BITS-1:0]  alloc_mask;
    logic [idba_pkg::WORD_BITS-1:0]  id_mask;
    logic [idba_pkg::WORD_BITS-1:0]  new_word;
    logic                            do_write;
    logic [idba_pkg::STATUS_W-1:0]   n_status;
    logic [idba_pkg::ID_W-1:0]       n_granted;
    idba_pkg::t_map_wr               map_wr;
    idba_pkg::t_sum_upd              sum_upd;

    assign id_word     = i_id_number >> idba_pkg::BIT_W;
    assign id_in_range = id_word < idba_pkg::ID_W'(idba_pkg::MAP_WORDS);
    assign out_free    = !r_out_valid || !i_out_stall;

    idba_map_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (map_wr),
        .o_rd_data (rd_word)
    );

    idba_summary u_summary (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (sum_upd),
        .o_any   (sum_any),
        .o_first (sum_first)
    );

    assign alloc_bit  = idba_pkg::ffs_word(rd_word);
    assign alloc_mask = idba_pkg::WORD_BITS'(1) << alloc_bit;
    assign id_mask    = idba_pkg::WORD_BITS'(1) << r_bit;

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        accept     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = (idba_pkg::t_cmd'(i_cmd) == idba_pkg::CMD_ALLOC)
                     ? sum_first : id_word[idba_pkg::WORD_W-1:0];
        done       = 1'b0;
        do_write   = 1'b0;
        new_word   = rd_word;
        n_status   = idba_pkg::ST_OK;
        n_granted  = '0;

        case (idba_pkg::t_cmd'(r_cmd))
            idba_pkg::CMD_ALLOC: begin
                if (r_found) begin
                    do_write  = 1'b1;
                    new_word  = rd_word & ~alloc_mask;
                    n_granted = idba_pkg::ID_W'({r_addr, alloc_bit});
                end else begin
                    n_status = idba_pkg::ST_FULL;
                end
            end
            idba_pkg::CMD_FREE: begin
                if (r_in_range) begin
                    if (|(rd_word & id_mask)) begin
                        n_status = idba_pkg::ST_DOUBLE_FREE;
                    end else begin
                        do_write = 1'b1;
                        new_word = rd_word | id_mask;
                    end
                end
            end
            idba_pkg::CMD_MARK: begin
                if (r_in_range) begin
                    if (!(|(rd_word & id_mask))) begin
                        n_status = idba_pkg::ST_IN_USE;
                    end else begin
                        do_write = 1'b1;
                        new_word = rd_word & ~id_mask;
                    end
                end
            end
            default: begin
                do_write = 1'b0;
            end
        endcase

        case (r_state)
            idba_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
                rd_en      = i_in_valid;
                if (i_in_valid) begin
                    n_state = idba_pkg::S_MOD;
                end
            end
            idba_pkg::S_MOD: begin
                if (out_free) begin
                    done    = 1'b1;
                    n_state = idba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = idba_pkg::S_IDLE;
            end
        endcase

        map_wr.en       = done && do_write;
        map_wr.addr     = r_addr;
        map_wr.data     = new_word;
        sum_upd.en      = done && do_write;
        sum_upd.addr    = r_addr;
        sum_upd.nonzero = |new_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= idba_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_cmd;
            r_addr     <= rd_addr;
            r_bit      <= i_id_number[idba_pkg::BIT_W-1:0];
            r_found    <= sum_any;
            r_in_range <= id_in_range;
        end
        if (done) begin
            r_status  <= n_status;
            r_granted <= n_granted;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_granted_id = r_granted;

endmodule
